>>> sv/kda_pkg.sv
package kda_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MS_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EN = 2'd3;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [MS_W-1:0] HOLD_RST     = 16'd1000;
  localparam logic [MS_W-1:0] REPEAT_RST   = 16'd200;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] hold_ms;
    logic [MS_W-1:0] repeat_ms;
    logic            repeat_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       held_nz;
  } status_t;

endpackage

>>> sv/key_debounce_autorepeat_core.sv
// Key debouncer with hold detection and optional auto-repeat. Each poll
// (raw key code plus millisecond timestamp) yields exactly one key_event,
// zero when nothing is reported. A poll enters an input register, the
// debounce state is updated by a single pass of compare logic once the
// output register can accept it, and the event is captured in that register;
// one poll is accepted every clock cycle unless the output side stalls.
// Configuration is written through a plain write port and should only
// change while no poll is in flight.
module key_debounce_autorepeat_core #(
  parameter int unsigned KEY_WIDTH  = 8,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [KEY_WIDTH-1:0]           raw_key_i,
  input  logic [TIME_WIDTH-1:0]          now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [KEY_WIDTH-1:0]           key_event_o,
  input  logic                           cfg_we_i,
  input  logic [kda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kda_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  kda_pkg::cfg_t    cfg;
  kda_pkg::status_t status;

  logic                  in_vld_q;
  logic [KEY_WIDTH-1:0]  in_key_q;
  logic [TIME_WIDTH-1:0] in_now_q;
  logic                  out_vld_q;
  logic [KEY_WIDTH-1:0]  out_key_q;
  logic [KEY_WIDTH-1:0]  event_d;
  logic                  advance, fire;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  kda_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kda_fsm #(
    .KEY_WIDTH  (KEY_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .key_i    (in_key_q),
    .now_i    (in_now_q),
    .cfg_i    (cfg),
    .event_o  (event_d),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_key_q <= raw_key_i;
      in_now_q <= now_ms_i;
    end
    if (fire) begin
      out_key_q <= event_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign key_event_o = out_key_q;

  // A latched key is non-zero exactly when the debouncer is out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == kda_pkg::PH_IDLE) == !status.held_nz)
    else $error("held key does not match debounce phase");

  // Every processed poll produces an event in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed poll lost its event");

  // A stalled output must not let the state advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> $stable(status) && $stable(out_key_q))
    else $error("state advanced while output stalled");

  // A stored poll is never overwritten before it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q && $stable(in_key_q) && $stable(in_now_q))
    else $error("pending poll overwritten");

endmodule

>>> sv/kda_cfg.sv
module kda_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kda_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kda_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output kda_pkg::cfg_t                   cfg_o
);

  kda_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= kda_pkg::DEBOUNCE_RST;
      cfg_q.hold_ms       <= kda_pkg::HOLD_RST;
      cfg_q.repeat_ms     <= kda_pkg::REPEAT_RST;
      cfg_q.repeat_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kda_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms   <= cfg_wdata_i;
        kda_pkg::CFG_HOLD:      cfg_q.hold_ms       <= cfg_wdata_i;
        kda_pkg::CFG_REPEAT:    cfg_q.repeat_ms     <= cfg_wdata_i;
        kda_pkg::CFG_REPEAT_EN: cfg_q.repeat_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/kda_fsm.sv
module kda_fsm #(
  parameter int unsigned KEY_WIDTH  = 8,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  kda_pkg::cfg_t         cfg_i,
  output logic [KEY_WIDTH-1:0]  event_o,
  output kda_pkg::status_t      status_o
);

  logic [1:0]            phase_q, phase_d;
  logic [KEY_WIDTH-1:0]  held_key_q, held_key_d;
  logic [TIME_WIDTH-1:0] press_time_q, press_time_d;
  logic [TIME_WIDTH-1:0] repeat_time_q, repeat_time_d;
  logic                  repeat_sent_q, repeat_sent_d;

  logic [TIME_WIDTH-1:0] el_press, el_repeat;
  logic                  debounce_done, hold_done, repeat_done, same_key;

  // Differences wrap modulo 2^TIME_WIDTH
  assign el_press      = now_i - press_time_q;
  assign el_repeat     = now_i - repeat_time_q;
  assign debounce_done = el_press >= TIME_WIDTH'(cfg_i.debounce_ms);
  assign hold_done     = el_press >= TIME_WIDTH'(cfg_i.hold_ms);
  assign repeat_done   = el_repeat > TIME_WIDTH'(cfg_i.repeat_ms);
  assign same_key      = key_i == held_key_q;

  always_comb begin
    phase_d       = phase_q;
    held_key_d    = held_key_q;
    press_time_d  = press_time_q;
    repeat_time_d = repeat_time_q;
    repeat_sent_d = repeat_sent_q;
    event_o       = '0;
    unique case (phase_q)
      kda_pkg::PH_IDLE: begin
        if (key_i != '0) begin
          phase_d      = kda_pkg::PH_WAIT;
          held_key_d   = key_i;
          press_time_d = now_i;
        end
      end
      kda_pkg::PH_WAIT: begin
        if (debounce_done) begin
          if (!same_key) begin
            phase_d    = kda_pkg::PH_IDLE;
            held_key_d = '0;
          end else begin
            phase_d = kda_pkg::PH_HELD;
            event_o = key_i;
          end
        end
      end
      kda_pkg::PH_HELD: begin
        if (!same_key) begin
          phase_d    = kda_pkg::PH_IDLE;
          held_key_d = '0;
        end else if (cfg_i.repeat_enable && hold_done) begin
          if (!repeat_sent_q) begin
            repeat_sent_d = 1'b1;
            repeat_time_d = now_i;
            event_o       = key_i;
          end else if (repeat_done) begin
            repeat_sent_d = 1'b0;
          end
        end
      end
      default: begin
        phase_d    = kda_pkg::PH_IDLE;
        held_key_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= kda_pkg::PH_IDLE;
      held_key_q    <= '0;
      press_time_q  <= '0;
      repeat_time_q <= '0;
      repeat_sent_q <= 1'b0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      held_key_q    <= held_key_d;
      press_time_q  <= press_time_d;
      repeat_time_q <= repeat_time_d;
      repeat_sent_q <= repeat_sent_d;
    end
  end

  assign status_o.phase   = phase_q;
  assign status_o.held_nz = held_key_q != '0;

endmodule
